[hdl/gpcm_pkg.sv]
// Shared types, constants and the exp table for the GPCM category probability block.
package gpcm_pkg;

    localparam int CAT_W      = 3;
    localparam int VAL_W      = 16;
    localparam int PROB_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_THR    = 6;
    localparam int EXP_W      = 17;

    localparam logic [16:0]       LOG2E_Q16 = 17'd94548;
    localparam logic [15:0]       LN2_Q16   = 16'd45426;
    localparam logic [PROB_W-1:0] PROB_ONE  = 16'd32768;
    localparam logic [EXP_W-1:0]  EXP_ONE   = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOPE = 3'd0,
        REG_TOP   = 3'd1,
        REG_THR1  = 3'd2,
        REG_THR2  = 3'd3,
        REG_THR3  = 3'd4,
        REG_THR4  = 3'd5,
        REG_THR5  = 3'd6,
        REG_THR6  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [CAT_W-1:0]        observed_category;
        logic signed [VAL_W-1:0] ability;
        logic signed [VAL_W-1:0] testlet_effect;
        logic                    response_present;
    } in_t;

    typedef struct packed {
        logic [PROB_W-1:0] probability;
        logic              category_invalid;
    } out_t;

    // Control that travels down the pipeline next to each beat.
    typedef struct packed {
        logic             valid;
        logic             present;
        logic             invalid;
        logic [CAT_W-1:0] cat;
    } ctl_t;

    // 2^(-idx/16) in Q.16, rounded.
    function automatic logic [EXP_W-1:0] pow2_frac(input logic [3:0] idx);
        logic [EXP_W-1:0] v;
        unique case (idx)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd62757;
            4'd2:  v = 17'd60097;
            4'd3:  v = 17'd57549;
            4'd4:  v = 17'd55109;
            4'd5:  v = 17'd52773;
            4'd6:  v = 17'd50535;
            4'd7:  v = 17'd48393;
            4'd8:  v = 17'd46341;
            4'd9:  v = 17'd44376;
            4'd10: v = 17'd42495;
            4'd11: v = 17'd40693;
            4'd12: v = 17'd38968;
            4'd13: v = 17'd37316;
            4'd14: v = 17'd35734;
            4'd15: v = 17'd34219;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

[hdl/gpcm_logit.sv]
// Logit front end: slope product, per-category logits and their maximum.
module gpcm_logit #(
    parameter int MAX_TOP_CATEGORY = 6,
    localparam int LANES = MAX_TOP_CATEGORY + 1,
    localparam int KW    = $clog2(LANES),
    localparam int LW    = 22 + KW
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gpcm_pkg::ctl_t          ctl_in,
    input  gpcm_pkg::in_t           item,
    input  logic signed [15:0]      slope,
    input  logic signed [15:0]      thr [1:gpcm_pkg::NUM_THR],
    input  logic [LANES-1:0]        lane_on,
    output gpcm_pkg::ctl_t          ctl,
    output logic signed [LW-1:0]    logit [LANES],
    output logic signed [LW-1:0]    lmax
);

    localparam int P = 2 ** $clog2(LANES);

    gpcm_pkg::ctl_t       ctl_a_reg, ctl_b_reg, ctl_c_reg;
    logic signed [31:0]   prod_a_reg;
    logic signed [15:0]   testlet_a_reg;
    logic signed [20:0]   s;
    logic signed [LW-1:0] logit_next [LANES];
    logic signed [LW-1:0] logit_b_reg [LANES];
    logic signed [LW-1:0] logit_c_reg [LANES];
    logic signed [LW-1:0] node [1:2*P-1];
    logic signed [LW-1:0] lmax_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_a_reg    <= slope * item.ability;
        testlet_a_reg <= item.testlet_effect;
    end

    // The arithmetic shift floors the Q8.24 product back to Q.12.
    assign s = 21'(prod_a_reg >>> 12) + {{5{testlet_a_reg[15]}}, testlet_a_reg};

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        localparam logic [LW-1:0] KV = LW'(k);
        logic [LW-1:0] b;
        if (k == 0)
        begin : g_zero
            assign b = '0;
        end
        else if (k <= gpcm_pkg::NUM_THR)
        begin : g_thr
            assign b = {{(LW-16){thr[k][15]}}, thr[k]};
        end
        else
        begin : g_none
            assign b = '0;
        end
        assign logit_next[k] = $signed({{(LW-21){s[20]}}, s} * KV - b);

        always_ff @(posedge clk)
        begin
            logit_b_reg[k] <= logit_next[k];
            logit_c_reg[k] <= logit_b_reg[k];
        end
    end

    // Compare tree; lanes not in use are replaced by category zero.
    always_comb
    begin
        for (int i = 0; i < P; i++)
        begin
            node[P+i] = logit_b_reg[0];
            if (i < LANES)
            begin
                if (lane_on[i])
                begin
                    node[P+i] = logit_b_reg[i];
                end
            end
        end
        for (int i = P - 1; i >= 1; i--)
        begin
            node[i] = (node[2*i] > node[2*i+1]) ? node[2*i] : node[2*i+1];
        end
    end

    always_ff @(posedge clk)
    begin
        lmax_reg <= node[1];
    end

    assign ctl   = ctl_c_reg;
    assign logit = logit_c_reg;
    assign lmax  = lmax_reg;

endmodule

[hdl/gpcm_exp.sv]
// One exponent lane: e = 65536 * exp(-d / 4096) by table and quadratic correction.
module gpcm_exp #(
    parameter int LW = 25
) (
    input  logic                         clk,
    input  logic [LW-1:0]                d,
    output logic [gpcm_pkg::EXP_W-1:0]   e
);

    localparam int YW = LW + 5;

    logic [LW+16:0]              yprod;
    logic [YW-1:0]               y_reg;
    logic [27:0]                 zprod;
    logic [11:0]                 z_reg;
    logic [3:0]                  i_e_reg, i_f_reg;
    logic [4:0]                  n_e_reg, n_f_reg;
    logic                        zero_e_reg, zero_f_reg;
    logic [23:0]                 zsq;
    logic [gpcm_pkg::EXP_W-1:0]  g_reg;
    logic [33:0]                 vprod;
    logic [gpcm_pkg::EXP_W-1:0]  v;
    logic [gpcm_pkg::EXP_W-1:0]  e_reg;

    assign yprod = (LW+17)'(d) * (LW+17)'(gpcm_pkg::LOG2E_Q16);
    assign zprod = 28'(y_reg[11:0]) * 28'(gpcm_pkg::LN2_Q16);
    assign zsq   = 24'(z_reg) * 24'(z_reg);
    assign vprod = 34'(gpcm_pkg::pow2_frac(i_f_reg)) * 34'(g_reg);
    assign v     = vprod[32:16];

    always_ff @(posedge clk)
    begin
        y_reg      <= yprod[LW+16:12];
        z_reg      <= zprod[27:16];
        i_e_reg    <= y_reg[15:12];
        n_e_reg    <= y_reg[20:16];
        zero_e_reg <= |y_reg[YW-1:21];
        g_reg      <= gpcm_pkg::EXP_ONE - 17'(z_reg) + 17'(zsq[23:17]);
        i_f_reg    <= i_e_reg;
        n_f_reg    <= n_e_reg;
        zero_f_reg <= zero_e_reg;
        e_reg      <= zero_f_reg ? '0 : (v >> n_f_reg);
    end

    assign e = e_reg;

endmodule

[hdl/gpcm_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module gpcm_div #(
    parameter int DW = 20,
    localparam int QW = gpcm_pkg::PROB_W,
    localparam int NW = DW + QW
) (
    input  logic            clk,
    input  logic            rst_n,
    input  gpcm_pkg::ctl_t  ctl_in,
    input  logic [NW-1:0]   num,
    input  logic [DW-1:0]   den,
    output gpcm_pkg::ctl_t  ctl_out,
    output logic [QW-1:0]   quo
);

    gpcm_pkg::ctl_t ctl_reg [QW];
    logic [NW-1:0]  rem_reg [QW];
    logic [QW-1:0]  quo_reg [QW];
    logic [DW-1:0]  den_reg [QW];

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        localparam int B = QW - 1 - j;
        gpcm_pkg::ctl_t ctl_i;
        logic [NW-1:0]  rem_i;
        logic [QW-1:0]  quo_i;
        logic [DW-1:0]  den_i;
        logic [NW-1:0]  shifted;
        logic           ge;
        logic [NW-1:0]  rem_next;
        logic [QW-1:0]  quo_next;

        if (j == 0)
        begin : g_first
            assign ctl_i = ctl_in;
            assign rem_i = num;
            assign quo_i = '0;
            assign den_i = den;
        end
        else
        begin : g_rest
            assign ctl_i = ctl_reg[j-1];
            assign rem_i = rem_reg[j-1];
            assign quo_i = quo_reg[j-1];
            assign den_i = den_reg[j-1];
        end

        always_comb
        begin
            shifted     = NW'(den_i) << B;
            ge          = rem_i >= shifted;
            rem_next    = ge ? rem_i - shifted : rem_i;
            quo_next    = quo_i;
            quo_next[B] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[j] <= '0;
            end
            else
            begin
                ctl_reg[j] <= ctl_i;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= rem_next;
            quo_reg[j] <= quo_next;
            den_reg[j] <= den_i;
        end
    end

    assign ctl_out = ctl_reg[QW-1];
    assign quo     = quo_reg[QW-1];

endmodule

[hdl/gpcm_category_probability.sv]
// Top level of the generalized partial credit model category probability block.
//
// Each start beat carries one person's response and yields exactly one result
// beat, strobed by result_valid for a single cycle. A new beat may be started
// in every cycle: busy is never raised, and results cannot be held off by the
// receiver, so beats flow at one per clock. The pipeline is made of three
// logit stages (slope product, logits, maximum tree), four exponent stages per
// category lane, one sum stage, a sixteen-stage divider that produces one
// quotient bit per stage, and the output register. Configuration writes are
// always ready; they must only be issued while no beat is in flight, since
// beats in the pipeline read the live registers. A missing response gives
// exactly one (32768), and an observed category above the top category gives
// zero with category_invalid set.
module gpcm_category_probability #(
    parameter int MAX_TOP_CATEGORY = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  gpcm_pkg::in_t                     item,
    output logic                              result_valid,
    output gpcm_pkg::out_t                    result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gpcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gpcm_pkg::VAL_W-1:0]        cfg_data
);

    localparam int LANES   = MAX_TOP_CATEGORY + 1;
    localparam int KW      = $clog2(LANES);
    localparam int LW      = 22 + KW;
    localparam int SUM_W   = gpcm_pkg::EXP_W + KW;
    localparam int NW      = SUM_W + gpcm_pkg::PROB_W;
    localparam int EXP_LAT = 4;
    localparam int LATENCY = 3 + EXP_LAT + 1 + gpcm_pkg::PROB_W + 1;

    // Configuration registers.
    logic signed [15:0] slope_reg;
    logic [2:0]         top_reg;
    logic signed [15:0] thr_reg [1:gpcm_pkg::NUM_THR];

    logic [KW-1:0]      kmax;
    logic [LANES-1:0]   lane_on;
    gpcm_pkg::ctl_t     ctl_in;

    gpcm_pkg::ctl_t       ctl_c;
    logic signed [LW-1:0] logit [LANES];
    logic signed [LW-1:0] lmax;
    logic [gpcm_pkg::EXP_W-1:0] e [LANES];

    gpcm_pkg::ctl_t       ctl_pipe_reg [EXP_LAT+1];
    logic [SUM_W-1:0]     sum_next, sum_reg;
    logic [gpcm_pkg::EXP_W-1:0] ex_next, ex_reg;
    logic [NW-1:0]        num;

    gpcm_pkg::ctl_t       ctl_d;
    logic [gpcm_pkg::PROB_W-1:0] quo;
    gpcm_pkg::out_t       result_next, result_reg;
    logic                 result_valid_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg <= 16'sd4096;
            top_reg   <= 3'd1;
            for (int i = 1; i <= gpcm_pkg::NUM_THR; i++)
            begin
                thr_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (gpcm_pkg::cfg_reg_t'(cfg_index))
                gpcm_pkg::REG_SLOPE: slope_reg <= cfg_data;
                gpcm_pkg::REG_TOP:   top_reg   <= cfg_data[2:0];
                gpcm_pkg::REG_THR1:  if (MAX_TOP_CATEGORY >= 1) thr_reg[1] <= cfg_data;
                gpcm_pkg::REG_THR2:  if (MAX_TOP_CATEGORY >= 2) thr_reg[2] <= cfg_data;
                gpcm_pkg::REG_THR3:  if (MAX_TOP_CATEGORY >= 3) thr_reg[3] <= cfg_data;
                gpcm_pkg::REG_THR4:  if (MAX_TOP_CATEGORY >= 4) thr_reg[4] <= cfg_data;
                gpcm_pkg::REG_THR5:  if (MAX_TOP_CATEGORY >= 5) thr_reg[5] <= cfg_data;
                gpcm_pkg::REG_THR6:  if (MAX_TOP_CATEGORY >= 6) thr_reg[6] <= cfg_data;
                default: ;
            endcase
        end
    end

    // The top category saturates at MAX_TOP_CATEGORY, the highest lane that is built.
    always_comb
    begin
        if (int'(top_reg) > MAX_TOP_CATEGORY)
        begin
            kmax = KW'(MAX_TOP_CATEGORY);
        end
        else
        begin
            kmax = KW'(top_reg);
        end
        for (int k = 0; k < LANES; k++)
        begin
            lane_on[k] = k <= int'(kmax);
        end
    end

    // The special cases are decided at entry and ride along with the beat.
    always_comb
    begin
        ctl_in.valid   = start && !busy;
        ctl_in.present = item.response_present;
        ctl_in.invalid = item.response_present &&
                         (int'(item.observed_category) > int'(kmax));
        ctl_in.cat     = item.observed_category;
    end

    gpcm_logit #(
        .MAX_TOP_CATEGORY (MAX_TOP_CATEGORY)
    ) u_logit (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_in),
        .item    (item),
        .slope   (slope_reg),
        .thr     (thr_reg),
        .lane_on (lane_on),
        .ctl     (ctl_c),
        .logit   (logit),
        .lmax    (lmax)
    );

    // Each lane exponentiates its distance below the largest logit.
    for (genvar k = 0; k < LANES; k++)
    begin : g_exp
        logic [LW-1:0] d;
        assign d = LW'(lmax - logit[k]);
        gpcm_exp #(
            .LW (LW)
        ) u_exp (
            .clk (clk),
            .d   (d),
            .e   (e[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= EXP_LAT; i++)
            begin
                ctl_pipe_reg[i] <= '0;
            end
        end
        else
        begin
            ctl_pipe_reg[0] <= ctl_c;
            for (int i = 1; i <= EXP_LAT; i++)
            begin
                ctl_pipe_reg[i] <= ctl_pipe_reg[i-1];
            end
        end
    end

    // Sum over the categories in use and pick out the observed one.
    always_comb
    begin
        sum_next = '0;
        ex_next  = '0;
        for (int k = 0; k < LANES; k++)
        begin
            if (lane_on[k])
            begin
                sum_next = sum_next + SUM_W'(e[k]);
            end
            if (int'(ctl_pipe_reg[EXP_LAT-1].cat) == k)
            begin
                ex_next = e[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        ex_reg  <= ex_next;
    end

    // Rounded share: (ex * 32768 + sum / 2) / sum.
    assign num = (NW'(ex_reg) << 15) + NW'(sum_reg >> 1);

    gpcm_div #(
        .DW (SUM_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_pipe_reg[EXP_LAT]),
        .num     (num),
        .den     (sum_reg),
        .ctl_out (ctl_d),
        .quo     (quo)
    );

    always_comb
    begin
        priority if (!ctl_d.present)
        begin
            result_next.probability      = gpcm_pkg::PROB_ONE;
            result_next.category_invalid = 1'b0;
        end
        else if (ctl_d.invalid)
        begin
            result_next.probability      = '0;
            result_next.category_invalid = 1'b1;
        end
        else
        begin
            result_next.probability      = quo;
            result_next.category_invalid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= ctl_d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Every started beat is answered by a result_valid strobe, and no strobe comes without a started beat.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY result_valid)
        else $error("started beat did not produce a result on time");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, LATENCY))
        else $error("result beat without a matching start");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.category_invalid |-> result.probability == '0)
        else $error("invalid category with nonzero probability");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.probability <= gpcm_pkg::PROB_ONE)
        else $error("probability above one");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the GPCM category probability block.
module tb;

    // Clock, reset and the block's ports.
    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    gpcm_pkg::in_t item;
    logic result_valid;
    gpcm_pkg::out_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [gpcm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [gpcm_pkg::VAL_W-1:0] cfg_data;

    gpcm_category_probability dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .result_valid(result_valid),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Pipeline depth of the block from an accepted beat to its result.
    localparam int PIPE_LATENCY = 25;
    localparam int IDLE_LIMIT   = 2000;

    // Register copies held by the predictor.
    logic signed [15:0] slope_q;
    logic [2:0] top_q;
    logic signed [15:0] thr_q [1:6];

    gpcm_pkg::in_t   pending_beats [$];
    gpcm_pkg::out_t  expected_probs [$];
    int    gap_left;
    int    next_gap;
    logic  driver_hold;
    int    fail_count = 0;
    int    idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [16:0] pow_table(input logic [3:0] i);
        logic [16:0] tab [16];
        tab = '{17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
                17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
                17'd38968, 17'd37316, 17'd35734, 17'd34219};
        return tab[i];
    endfunction

    // Approximate 65536 * exp(-d / 4096) the same way the hardware does.
    function automatic logic [63:0] exp_approx(input logic [63:0] d);
        logic [63:0] y;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] z;
        logic [63:0] g;
        logic [63:0] t;
        y = (d * 64'd94548) >> 12;
        n = y >> 16;
        r = y & 64'hFFF;
        if (n > 31)
            return 64'd0;
        z = (r * 64'd45426) >> 16;
        g = 64'd65536 - z + ((z * z) >> 17);
        t = 64'(pow_table(4'(y >> 12)));
        return ((t * g) >> 16) >> n;
    endfunction

    // Expected result of one response under the current registers.
    function automatic gpcm_pkg::out_t predict_probability(input gpcm_pkg::in_t b);
        gpcm_pkg::out_t o;
        longint s;
        longint prod;
        longint lg [0:6];
        longint lmax;
        logic [63:0] e;
        logic [63:0] total;
        logic [63:0] ex;
        int kmax;
        kmax = (top_q > 6) ? 6 : int'(top_q);
        o.category_invalid = 1'b0;
        if (!b.response_present)
        begin
            o.probability = gpcm_pkg::PROB_ONE;
            return o;
        end
        if (int'(b.observed_category) > kmax)
        begin
            o.probability = '0;
            o.category_invalid = 1'b1;
            return o;
        end
        prod = longint'(slope_q) * longint'(b.ability);
        s = (prod >>> 12) + longint'(b.testlet_effect);
        lmax = 0;
        for (int k = 0; k <= kmax; k++)
        begin
            lg[k] = longint'(k) * s - ((k == 0) ? 0 : longint'(thr_q[k]));
            if (k == 0 || lg[k] > lmax)
                lmax = lg[k];
        end
        total = 0;
        ex = 0;
        for (int k = 0; k <= kmax; k++)
        begin
            e = exp_approx(64'(lmax - lg[k]));
            total += e;
            if (k == int'(b.observed_category))
                ex = e;
        end
        o.probability = 16'((ex * 64'd32768 + (total >> 1)) / total);
        return o;
    endfunction

    // Driver: one beat from the queue after a random gap, or a hold while draining.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
            gap_left <= 0;
        end
        else
        begin
            next_gap = gap_left;
            if (start && !busy)
            begin
                expected_probs.push_back(predict_probability(item));
                next_gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 8));
            end
            if (start && busy)
                start <= 1'b1;
            else if (next_gap == 0 && !driver_hold && pending_beats.size() > 0)
            begin
                start <= 1'b1;
                item <= pending_beats.pop_front();
                gap_left <= 0;
            end
            else
            begin
                start <= 1'b0;
                gap_left <= (next_gap > 0) ? next_gap - 1 : 0;
            end
        end
    end

    // Monitor: compare each strobed result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_probs.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: prob=%0d inv=%0b",
                             result.probability, result.category_invalid);
            end
            else
            begin
                gpcm_pkg::out_t want;
                want = expected_probs.pop_front();
                if (want !== result)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: want prob=%0d inv=%0b got prob=%0d inv=%0b",
                                 want.probability, want.category_invalid,
                                 result.probability, result.category_invalid);
                end
            end
        end
    end

    // Watchdog: counts cycles in which no beat moves either way and no register write is offered.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || cfg_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Register write through the config channel; also updates the predictor copy.
    task automatic write_reg(input gpcm_pkg::cfg_reg_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            gpcm_pkg::REG_SLOPE: slope_q = val;
            gpcm_pkg::REG_TOP:   top_q = val[2:0];
            default:             thr_q[int'(idx) - 1] = val;
        endcase
    endtask

    // Wait until every queued beat is accepted and every result has come back.
    task automatic drain();
        while (pending_beats.size() > 0 || start)
            @(posedge clk);
        while (expected_probs.size() > 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(0, 16384)) - 8192);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_beat(input logic [2:0] c, input logic [15:0] a,
                            input logic [15:0] u, input logic p);
        gpcm_pkg::in_t b;
        b.observed_category = c;
        b.ability = a;
        b.testlet_effect = u;
        b.response_present = p;
        pending_beats.push_back(b);
    endtask

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
        begin
            add_beat(3'($urandom_range(0, 7)), rand_val(),
                     ($urandom_range(0, 3) == 0) ? 16'h0 : rand_val(),
                     $urandom_range(0, 7) != 0);
        end
        drain();
    endtask

    task automatic random_config(input logic [2:0] top);
        write_reg(gpcm_pkg::REG_SLOPE, rand_val());
        write_reg(gpcm_pkg::REG_TOP, 16'(top));
        for (int k = 0; k < gpcm_pkg::NUM_THR; k++)
            write_reg(gpcm_pkg::cfg_reg_t'(int'(gpcm_pkg::REG_THR1) + k), rand_val());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        driver_hold = 1'b0;
        slope_q = 16'sd4096;
        top_q = 3'd1;
        for (int k = 1; k <= 6; k++)
            thr_q[k] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats at reset settings: no response, out of range, field extremes.
        add_beat(3'd5, 16'h1234, 16'h0, 1'b0);
        add_beat(3'd7, 16'h0, 16'h0, 1'b1);
        add_beat(3'd2, 16'h0, 16'h0, 1'b1);
        add_beat(3'd0, 16'h0, 16'h0, 1'b1);
        add_beat(3'd1, 16'h7FFF, 16'h7FFF, 1'b1);
        add_beat(3'd1, 16'h8000, 16'h8000, 1'b1);
        add_beat(3'd0, 16'h8000, 16'h7FFF, 1'b1);
        add_beat(3'd1, 16'hFFFF, 16'h0001, 1'b1);
        drain();

        // Top category zero and saturated top category seven, extreme slopes.
        write_reg(gpcm_pkg::REG_TOP, 16'd0);
        write_reg(gpcm_pkg::REG_SLOPE, 16'h8000);
        add_beat(3'd0, 16'h7FFF, 16'h1000, 1'b1);
        add_beat(3'd1, 16'h7FFF, 16'h1000, 1'b1);
        drain();
        write_reg(gpcm_pkg::REG_TOP, 16'd7);
        write_reg(gpcm_pkg::REG_SLOPE, 16'h7FFF);
        for (int k = 0; k < gpcm_pkg::NUM_THR; k++)
            write_reg(gpcm_pkg::cfg_reg_t'(int'(gpcm_pkg::REG_THR1) + k),
                      (k % 2) ? 16'h8000 : 16'h7FFF);
        for (int c = 0; c < 8; c++)
            add_beat(3'(c), 16'h8000, 16'h7FFF, 1'b1);
        add_beat(3'd3, 16'h0800, 16'h0, 1'b1);
        drain();

        // Random phases across several settings, including an empty pass with the driver held off.
        for (int ph = 0; ph < 10; ph++)
        begin
            random_config((ph < 8) ? 3'($urandom_range(1, 6)) : 3'(ph - 2));
            if (ph == 4)
            begin
                driver_hold = 1'b1;
                random_phase(0);
                driver_hold = 1'b0;
            end
            random_phase(120);
        end

        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
